FILE: design/mcv_pkg.sv
// shared types, constants and helpers for the mesh container validator
`default_nettype none

package mcv_pkg;

   // header layout
   localparam int unsigned HEADER_BYTES = 20;
   localparam logic [24:0] POS_MAX      = 25'h1FFFFFF;
   localparam logic [31:0] MAGIC_WORD   = 32'h48534D51;
   localparam logic [31:0] VERSION_WORD = 32'd1;
   localparam logic [23:0] SIZE_RESET   = 24'd12582912;

   // byte offsets that close each header word
   localparam logic [4:0] OFS_MAGIC_END   = 5'd3;
   localparam logic [4:0] OFS_VERSION_END = 5'd7;
   localparam logic [4:0] OFS_FLAGS_END   = 5'd11;
   localparam logic [4:0] OFS_VERTEX_END  = 5'd15;
   localparam logic [4:0] OFS_INDEX_B0    = 5'd16;
   localparam logic [4:0] OFS_INDEX_B1    = 5'd17;
   localparam logic [4:0] OFS_INDEX_B2    = 5'd18;
   localparam logic [4:0] OFS_INDEX_END   = 5'd19;

   // status codes
   localparam logic [3:0] ST_OK            = 4'd0;
   localparam logic [3:0] ST_HEADER_SHORT  = 4'd1;
   localparam logic [3:0] ST_MAGIC         = 4'd2;
   localparam logic [3:0] ST_VERSION       = 4'd3;
   localparam logic [3:0] ST_FLAGS         = 4'd4;
   localparam logic [3:0] ST_VERTEX_COUNT  = 4'd5;
   localparam logic [3:0] ST_INDEX_FEW     = 4'd6;
   localparam logic [3:0] ST_INDEX_TRIPLE  = 4'd7;
   localparam logic [3:0] ST_TOO_LARGE     = 4'd8;
   localparam logic [3:0] ST_PAYLOAD_SHORT = 4'd9;
   localparam logic [3:0] ST_TRAILING      = 4'd10;
   localparam logic [3:0] ST_NON_FINITE    = 4'd11;
   localparam logic [3:0] ST_INDEX_RANGE   = 4'd12;

   // one input transaction
   typedef struct packed {
      logic       has_byte;
      logic [7:0] data_byte;
      logic       last;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] vertex_total;
      logic [31:0] index_total;
   } result_type;

   // residue mod 3 of a small value
   function automatic logic [1:0] mod3_small(input logic [3:0] v);
      logic [1:0] r;
      case (v)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
         4'd2, 4'd5, 4'd8, 4'd11, 4'd14:       r = 2'd2;
         default:                              r = 2'd0;
      endcase
      return r;
   endfunction

   // residue mod 3 of a byte: base-4 digits each weigh 1 mod 3
   function automatic logic [1:0] byte_mod3(input logic [7:0] b);
      logic [3:0] s;
      s = {2'b00, b[7:6]} + {2'b00, b[5:4]} + {2'b00, b[3:2]} + {2'b00, b[1:0]};
      return mod3_small(s);
   endfunction

endpackage

`default_nettype wire

FILE: design/mcv_if.sv
// request and response channel interfaces of the mesh container validator
`default_nettype none

interface mcv_req_if;
   logic       valid;
   logic       ready;
   logic       has_byte;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, has_byte, data_byte, last, input ready);
   modport sink   (input valid, has_byte, data_byte, last, output ready);
endinterface

interface mcv_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [15:0] vertex_total;
   logic [31:0] index_total;

   modport source (output valid, status, vertex_total, index_total, input ready);
   modport sink   (input valid, status, vertex_total, index_total, output ready);
endinterface

`default_nettype wire

FILE: design/mcv_parser.sv
// byte parser: header decode, content checks and status for one buffer
`default_nettype none

module mcv_parser
   import mcv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire item_type    item,
   input  wire logic [23:0] size_limit,
   output result_type       result
);

   logic [24:0] pos_ff,    pos_in;
   logic [31:0] wg_ff,     wg_in;
   logic [2:0]  mf_ff,     mf_in;
   logic [31:0] vertex_ff, vertex_in;
   logic [31:0] index_ff,  index_in;
   logic [34:0] exp_ff,    exp_in;
   logic [3:0]  hf_ff,     hf_in;
   logic [3:0]  cf_ff,     cf_in;
   logic [19:0] coord_ff,  coord_in;
   logic        vok_ff,    vok_in;
   logic [1:0]  mod_ff,    mod_in;

   logic [1:0]  mod_next;
   logic [3:0]  code;

   // next buffer state for this transaction
   always_comb begin
      pos_in    = pos_ff;
      wg_in     = wg_ff;
      mf_in     = mf_ff;
      vertex_in = vertex_ff;
      index_in  = index_ff;
      exp_in    = exp_ff;
      hf_in     = hf_ff;
      cf_in     = cf_ff;
      coord_in  = coord_ff;
      vok_in    = vok_ff;
      mod_in    = mod_ff;
      mod_next  = mod3_small({2'b00, mod_ff} + {2'b00, byte_mod3(item.data_byte)});
      code      = ST_OK;
      if (item.has_byte && (pos_ff != POS_MAX)) begin
         pos_in = pos_ff + 25'd1;
         wg_in  = {item.data_byte, wg_ff[31:8]};
         if (pos_ff < 25'(HEADER_BYTES)) begin
            case (pos_ff[4:0])
               OFS_MAGIC_END: begin
                  if (wg_in == MAGIC_WORD) mf_in[0] = 1'b1;
               end
               OFS_VERSION_END: begin
                  if (wg_in == VERSION_WORD) mf_in[1] = 1'b1;
               end
               OFS_FLAGS_END: begin
                  if (wg_in == 32'd0) mf_in[2] = 1'b1;
               end
               OFS_VERTEX_END: begin
                  vertex_in = wg_in;
                  vok_in    = (wg_in >= 32'd3) && (wg_in <= 32'd65535);
                  // end of coordinates: header plus twelve bytes per vertex
                  coord_in  = 20'(HEADER_BYTES) + {1'b0, wg_in[15:0], 3'b000}
                              + {2'b00, wg_in[15:0], 2'b00};
               end
               OFS_INDEX_B0, OFS_INDEX_B1, OFS_INDEX_B2: begin
                  mod_in = mod_next;
               end
               OFS_INDEX_END: begin
                  mod_in   = mod_next;
                  index_in = wg_in;
                  // header judgement in file priority
                  if (!mf_ff[0])              code = ST_MAGIC;
                  else if (!mf_ff[1])         code = ST_VERSION;
                  else if (!mf_ff[2])         code = ST_FLAGS;
                  else if (!vok_ff)           code = ST_VERTEX_COUNT;
                  else if (wg_in < 32'd3)     code = ST_INDEX_FEW;
                  else if (mod_next != 2'd0)  code = ST_INDEX_TRIPLE;
                  else                        code = ST_OK;
                  hf_in  = code;
                  exp_in = (code == ST_OK)
                           ? ({15'd0, coord_ff} + {2'b00, wg_in, 1'b0})
                           : 35'd0;
               end
               default: begin
               end
            endcase
         end else if ((hf_ff == ST_OK) && (cf_ff == ST_OK)) begin
            // payload: coordinates, then 16-bit indices
            if (pos_ff < {5'd0, coord_ff}) begin
               if ((pos_ff[1:0] == 2'd3) && (wg_in[30:23] == 8'hFF))
                  cf_in = ST_NON_FINITE;
            end else if ({10'd0, pos_ff} < exp_ff) begin
               if (pos_ff[0] && ({16'd0, wg_in[31:16]} >= vertex_ff))
                  cf_in = ST_INDEX_RANGE;
            end
         end
      end
   end

   // status for a transaction that ends the buffer
   always_comb begin
      if (pos_in < 25'(HEADER_BYTES)) begin
         result.status       = ST_HEADER_SHORT;
         result.vertex_total = 16'd0;
         result.index_total  = 32'd0;
      end else begin
         result.vertex_total = vertex_in[15:0];
         result.index_total  = index_in;
         if (hf_in != ST_OK)                       result.status = hf_in;
         else if (exp_in > {11'd0, size_limit})    result.status = ST_TOO_LARGE;
         else if ({10'd0, pos_in} < exp_in)        result.status = ST_PAYLOAD_SHORT;
         else if ({10'd0, pos_in} > exp_in)        result.status = ST_TRAILING;
         else                                      result.status = cf_in;
      end
   end

   // buffer state, cleared after each result
   always_ff @(posedge clock) begin
      if (reset || (step && item.last)) begin
         pos_ff    <= '0;
         wg_ff     <= '0;
         mf_ff     <= '0;
         vertex_ff <= '0;
         index_ff  <= '0;
         exp_ff    <= '0;
         hf_ff     <= '0;
         cf_ff     <= '0;
         coord_ff  <= '0;
         vok_ff    <= 1'b0;
         mod_ff    <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         wg_ff     <= wg_in;
         mf_ff     <= mf_in;
         vertex_ff <= vertex_in;
         index_ff  <= index_in;
         exp_ff    <= exp_in;
         hf_ff     <= hf_in;
         cf_ff     <= cf_in;
         coord_ff  <= coord_in;
         vok_ff    <= vok_in;
         mod_ff    <= mod_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/mesh_container_validator.sv
// Mesh container validator: checks a mesh buffer streamed at most one byte per
// transaction and returns one status transaction when the buffer ends.
// req_if carries has_byte, data_byte and last; a transaction with last set
// closes the buffer and yields one rsp_if transaction (status, vertex_total,
// index_total). Other request transactions yield nothing.
// csr_wr_en/csr_wr_data write size_limit, the largest accepted total size;
// write it only while no buffer is in progress.
// A request lands in the input register when it is accepted; the parse step
// then takes it from there and, for a closing request, loads the response
// register once that register is free or being emptied by the receiver.
// Throughput: one byte per cycle unless a closing request waits on a full
// response register; the parse step is combinational between the two registers.
// When the receiver stalls, the response register holds its transaction;
// one further request is still taken into the input register, and request
// bytes keep flowing as long as they do not close a buffer.
// Reset (synchronous, active high) empties both registers, clears all
// buffer state and sets size_limit to 12582912.
`default_nettype none

module mesh_container_validator
   import mcv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [23:0] csr_wr_data,
   mcv_req_if.sink          req_if,
   mcv_rsp_if.source        rsp_if
);

   logic        in_valid_ff, in_valid_in;
   item_type    in_item_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff;
   logic [23:0] size_limit_ff;
   logic        advance;
   logic        req_take;
   result_type  parse_result;

   // the parse step may proceed unless it closes a buffer into a full response slot not being taken
   assign advance  = in_valid_ff && (!in_item_ff.last || !rsp_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;

   assign req_if.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_item_ff.last) || (rsp_valid_ff && !rsp_if.ready);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_item_ff.has_byte  <= req_if.has_byte;
         in_item_ff.data_byte <= req_if.data_byte;
         in_item_ff.last      <= req_if.last;
      end
   end

   // size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_limit_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_limit_ff <= csr_wr_data;
      end
   end

   mcv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item       (in_item_ff),
      .size_limit (size_limit_ff),
      .result     (parse_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance && in_item_ff.last) begin
         rsp_data_ff <= parse_result;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_data_ff.status;
   assign rsp_if.vertex_total = rsp_data_ff.vertex_total;
   assign rsp_if.index_total  = rsp_data_ff.index_total;

endmodule

`default_nettype wire
